// ===== rtl/core/sh_eval_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the spherical harmonics evaluator.
// Used by sh_eval_cordic and spherical_harmonics_eval; depends on nothing.
package sh_eval_pkg;

  localparam int P_W          = 48;
  localparam int TRIG_W       = 17;
  localparam int CORDIC_STEPS = 17;
  localparam int CORDIC_W     = 34;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [P_W-1:0]      P_ONE     = 48'sd1048576;
  localparam logic signed [P_W-1:0]      P_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [P_W-1:0]      P_MIN     = 48'sh8000_0000_0000;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430
  };

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TH_WAIT,
    ST_INIT,
    ST_R_RD,
    ST_R_M1,
    ST_R_M2,
    ST_R_M3,
    ST_R_M4,
    ST_R_M5,
    ST_R_DIV,
    ST_R_WR,
    ST_E_RD,
    ST_E_LD,
    ST_E_WAIT,
    ST_E_NORM,
    ST_E_MR,
    ST_E_MI,
    ST_E_OUT
  } state_e;

  // normalization constant: shift t and divisor s = isqrt(F * 4^t)
  typedef struct packed {
    logic [4:0]  t;
    logic [31:0] s;
  } norm_t;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_v;
    longint unsigned rem;
    res   = 0;
    bit_v = 64'd1 << 62;
    rem   = v;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic norm_t norm_entry(int n, int m);
    longint unsigned f;
    int              t;
    norm_t           r;
    f = 1;
    for (int i = n - m + 1; i <= n + m; i++) f = f * longint'(i);
    t = 0;
    while (t < 30 && f < (64'd1 << (60 - 2 * t))) t++;
    r.t = 5'(t);
    r.s = 32'(isqrt64(f << (2 * t)));
    return r;
  endfunction

endpackage

// ===== rtl/core/sh_eval_cordic.sv =====
// Iterative 17-step CORDIC giving sine and cosine of a 16-bit turn fraction, rounded to Q1.15.
// Uses sh_eval_pkg for the arctangent table and widths.
module sh_eval_cordic (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [15:0]                             angle_i,
  output logic                                    busy_o,
  output logic signed [sh_eval_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [sh_eval_pkg::TRIG_W-1:0]   sin_o
);

  localparam int CW = sh_eval_pkg::CORDIC_W;
  localparam int TW = sh_eval_pkg::TRIG_W;

  logic                 busy_q;
  logic [4:0]           step_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic [1:0]           quad_q;

  logic signed [CW-1:0] dx, dy, atan;
  logic        [CW-1:0] mag_x, mag_y, rnd_x, rnd_y;
  logic signed [TW-1:0] cq, sq;

  always_comb begin
    dx   = y_q >>> step_q;
    dy   = x_q >>> step_q;
    atan = CW'(sh_eval_pkg::ATAN_TURNS[step_q]);
    // round half away from zero down to Q1.15
    mag_x = x_q[CW-1] ? CW'(-x_q) : CW'(x_q);
    mag_y = y_q[CW-1] ? CW'(-y_q) : CW'(y_q);
    rnd_x = (mag_x + CW'(16384)) >> 15;
    rnd_y = (mag_y + CW'(16384)) >> 15;
    cq = x_q[CW-1] ? -TW'(rnd_x) : TW'(rnd_x);
    sq = y_q[CW-1] ? -TW'(rnd_y) : TW'(rnd_y);
    case (quad_q)
      2'd0: begin
        cos_o = cq;
        sin_o = sq;
      end
      2'd1: begin
        cos_o = -sq;
        sin_o = cq;
      end
      2'd2: begin
        cos_o = -cq;
        sin_o = -sq;
      end
      default: begin
        cos_o = sq;
        sin_o = -cq;
      end
    endcase
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'(sh_eval_pkg::CORDIC_STEPS - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= sh_eval_pkg::CORDIC_X0;
      y_q    <= '0;
      z_q    <= CW'({angle_i[13:0], 16'h0000});
      quad_q <= angle_i[15:14];
    end else if (busy_q) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan;
      end
    end
  end

endmodule

// ===== rtl/core/spherical_harmonics_eval.sv =====
// Spherical harmonics evaluator: Legendre recurrence, normalization and phase rotation.
// Depends on sh_eval_pkg and sh_eval_cordic.
//
//   port group   dir   handshake             payload
//   config       in    orders_used_we_i      orders_used_i
//   direction    in    in_valid/in_ready     theta_i, phi_i
//   harmonic     out   out_valid/out_ready   degree_o, order_o, y_real_o, y_imag_o, last_o
//
// One direction computes R = N(N-1)/2 off-diagonal recurrence entries and H = N(N+1)/2
// results. Its duration is set by the one-bit-per-cycle divider shared between the
// recurrence and the normalization, and by the 17-step CORDIC per result.
// in_ready_o is high only while idle; a stalled output holds the sequencer before the next
// result is loaded. Reset is asynchronous and active low; the store needs no clearing.
module spherical_harmonics_eval #(
  parameter int MAX_ORDERS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               orders_used_we_i,
  input  logic [3:0]         orders_used_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        theta_i,
  input  logic [15:0]        phi_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         degree_o,
  output logic [2:0]         order_o,
  output logic signed [31:0] y_real_o,
  output logic signed [31:0] y_imag_o,
  output logic               last_o
);

  localparam int DEPTH = MAX_ORDERS * (MAX_ORDERS + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(MAX_ORDERS + 1);
  localparam int TW    = sh_eval_pkg::TRIG_W;
  localparam int PW    = sh_eval_pkg::P_W;

  sh_eval_pkg::state_e state_q, state_d;

  logic [3:0]    orders_used_q;
  logic [LW-1:0] l_q, m_q, nord_q;
  logic [AW-1:0] base_q;
  logic [15:0]   phase_q, phi_q;
  logic          out_valid_q;

  // legendre store and constant normalization table
  logic signed [PW-1:0]  store_mem [DEPTH];
  logic signed [PW-1:0]  rd_q;
  sh_eval_pkg::norm_t    norm_tab [DEPTH];

  for (genvar gl = 0; gl < MAX_ORDERS; gl++) begin : g_n
    for (genvar gm = 0; gm <= gl; gm++) begin : g_m
      localparam sh_eval_pkg::norm_t NE = sh_eval_pkg::norm_entry(gl, gm);
      assign norm_tab[gl * (gl + 1) / 2 + gm] = NE;
    end
  end

  // datapath registers
  logic [63:0]          prod_q;
  logic signed [TW-1:0] x_q;
  logic [15:0]          s_q;
  logic                 neg1_q, numneg_q, neg_q, sat_q;
  logic [PW-1:0]        mr_q;
  logic signed [PW-1:0] p2_q, p_q;
  logic signed [55:0]   a_q;
  logic signed [63:0]   v_q;
  logic [30:0]          amp_q;
  logic signed [TW-1:0] cos_q, sin_q;
  logic signed [31:0]   yr_q;
  logic [2:0]           deg_q, ord_q;
  logic signed [31:0]   yre_q, yim_q;
  logic                 last_q;

  // shared divider
  logic [63:0] div_rem_q, div_quo_q;
  logic [87:0] div_dvd_q;
  logic [31:0] div_den_q;
  logic [5:0]  div_cnt_q;
  logic [63:0] div_sh;
  logic        div_ge;

  // control
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic signed [PW-1:0] mem_wdata;
  logic          mul_en;
  logic [PW-1:0] mul_a;
  logic [15:0]   mul_b;
  logic          cor_start, cor_busy;
  logic [15:0]   cor_angle;
  logic signed [TW-1:0] cor_cos, cor_sin;
  logic          div_start;
  logic [63:0]   div_rem_d;
  logic [87:0]   div_dvd_d;
  logic [31:0]   div_den_d;
  logic [5:0]    div_cnt_d;
  logic          out_load;

  logic          diag, has_p2, last_w, in_xfer;
  logic [AW-1:0] addr_cur, addr_p1, addr_p2;
  logic [PW-1:0] rd_mag, p2_mag;
  logic [63:0]   rnd;
  logic signed [55:0] b_w, num_w;
  logic [55:0]   un_w;
  logic signed [63:0] v_sat_src;
  logic signed [PW-1:0] v_sat;
  sh_eval_pkg::norm_t ne_w;
  logic [87:0]   wide_w;
  logic [32:0]   quo33;
  logic [32:0]   ymag;
  logic signed [33:0] yval;
  logic signed [31:0] y_sat;
  logic [LW-1:0] nord_w;

  sh_eval_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .busy_o  (cor_busy),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  always_comb begin
    in_xfer  = in_valid_i && (state_q == sh_eval_pkg::ST_IDLE);
    diag     = (m_q == l_q);
    has_p2   = ((LW + 1)'(m_q) + (LW + 1)'(2)) <= (LW + 1)'(l_q);
    last_w   = diag && ((LW + 1)'(l_q) + (LW + 1)'(1) == (LW + 1)'(nord_q));
    addr_cur = AW'(base_q + AW'(m_q));
    addr_p1  = AW'(base_q - AW'(l_q) + (diag ? AW'(l_q - 1'b1) : AW'(m_q)));
    addr_p2  = AW'(base_q - AW'(l_q) - AW'(l_q) + AW'(1) + AW'(m_q));
    rd_mag   = rd_q[PW-1] ? PW'(-rd_q) : PW'(rd_q);
    p2_mag   = p2_q[PW-1] ? PW'(-p2_q) : PW'(p2_q);
    rnd      = prod_q + 64'd16384;
    b_w      = p2_q[PW-1] ? -$signed(56'(prod_q)) : $signed(56'(prod_q));
    num_w    = a_q - b_w;
    un_w     = num_w[55] ? 56'(-num_w) : 56'(num_w);
    v_sat_src = v_q;
    if (v_sat_src > 64'(sh_eval_pkg::P_MAX)) begin
      v_sat = sh_eval_pkg::P_MAX;
    end else if (v_sat_src < 64'(sh_eval_pkg::P_MIN)) begin
      v_sat = sh_eval_pkg::P_MIN;
    end else begin
      v_sat = PW'(v_sat_src);
    end
    ne_w   = norm_tab[addr_cur];
    wide_w = 88'(rd_mag) << (7'd10 + 7'(ne_w.t));
    quo33  = div_quo_q[32:0];
    ymag   = rnd[47:15];
    yval   = (neg_q ^ (state_q == sh_eval_pkg::ST_E_MI ? cos_q[TW-1] : sin_q[TW-1]))
             ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
    if (yval > 34'sh0_7FFF_FFFF) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (yval < -34'sh0_8000_0000) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = 32'(yval);
    end
    if (orders_used_q == 4'd0) begin
      nord_w = LW'(1);
    end else if (32'(orders_used_q) > MAX_ORDERS) begin
      nord_w = LW'(MAX_ORDERS);
    end else begin
      nord_w = LW'(orders_used_q);
    end
    div_sh = {div_rem_q[62:0], div_dvd_q[87]};
    div_ge = div_sh >= {32'h0, div_den_q};
  end

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_raddr = addr_cur;
    mem_wdata = v_sat;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_angle = phase_q;
    div_start = 1'b0;
    div_rem_d = '0;
    div_dvd_d = '0;
    div_den_d = '0;
    div_cnt_d = '0;
    out_load  = 1'b0;
    case (state_q)
      sh_eval_pkg::ST_IDLE: begin
        cor_angle = theta_i;
        if (in_valid_i) begin
          cor_start = 1'b1;
          state_d   = sh_eval_pkg::ST_TH_WAIT;
        end
      end
      sh_eval_pkg::ST_TH_WAIT: begin
        if (!cor_busy) state_d = sh_eval_pkg::ST_INIT;
      end
      sh_eval_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = sh_eval_pkg::P_ONE;
        state_d   = (nord_q == LW'(1)) ? sh_eval_pkg::ST_E_RD : sh_eval_pkg::ST_R_RD;
      end
      sh_eval_pkg::ST_R_RD: begin
        mem_raddr = addr_p1;
        state_d   = sh_eval_pkg::ST_R_M1;
      end
      sh_eval_pkg::ST_R_M1: begin
        mul_en    = 1'b1;
        mul_a     = rd_mag;
        mul_b     = diag ? s_q : (x_q[TW-1] ? 16'(-x_q) : 16'(x_q));
        mem_raddr = addr_p2;
        state_d   = sh_eval_pkg::ST_R_M2;
      end
      sh_eval_pkg::ST_R_M2: begin
        state_d = sh_eval_pkg::ST_R_M3;
      end
      sh_eval_pkg::ST_R_M3: begin
        mul_en  = 1'b1;
        mul_a   = mr_q;
        mul_b   = 16'({l_q, 1'b0}) - 16'd1;
        state_d = sh_eval_pkg::ST_R_M4;
      end
      sh_eval_pkg::ST_R_M4: begin
        mul_en  = 1'b1;
        mul_a   = p2_mag;
        mul_b   = 16'(l_q) + 16'(m_q) - 16'd1;
        state_d = sh_eval_pkg::ST_R_M5;
      end
      sh_eval_pkg::ST_R_M5: begin
        if (diag) begin
          state_d = sh_eval_pkg::ST_R_WR;
        end else begin
          // round half away from zero: (2|num| + d) / (2d)
          div_start = 1'b1;
          div_dvd_d = {57'({un_w, 1'b0}) + 57'(l_q - m_q), 31'h0};
          div_den_d = 32'(l_q - m_q) << 1;
          div_cnt_d = 6'd57;
          state_d   = sh_eval_pkg::ST_R_DIV;
        end
      end
      sh_eval_pkg::ST_R_DIV: begin
        if (div_cnt_q == 6'd0) state_d = sh_eval_pkg::ST_R_WR;
      end
      sh_eval_pkg::ST_R_WR: begin
        mem_we = 1'b1;
        if (diag && ((LW + 1)'(l_q) + (LW + 1)'(1) == (LW + 1)'(nord_q))) begin
          state_d = sh_eval_pkg::ST_E_RD;
        end else begin
          state_d = sh_eval_pkg::ST_R_RD;
        end
      end
      sh_eval_pkg::ST_E_RD: begin
        state_d = sh_eval_pkg::ST_E_LD;
      end
      sh_eval_pkg::ST_E_LD: begin
        cor_start = 1'b1;
        div_start = 1'b1;
        div_rem_d = 64'(wide_w[87:33]);
        div_dvd_d = {wide_w[32:0], 55'h0};
        div_den_d = ne_w.s;
        div_cnt_d = 6'd33;
        state_d   = sh_eval_pkg::ST_E_WAIT;
      end
      sh_eval_pkg::ST_E_WAIT: begin
        if (!cor_busy && div_cnt_q == 6'd0) state_d = sh_eval_pkg::ST_E_NORM;
      end
      sh_eval_pkg::ST_E_NORM: begin
        state_d = sh_eval_pkg::ST_E_MR;
      end
      sh_eval_pkg::ST_E_MR: begin
        mul_en  = 1'b1;
        mul_a   = PW'(amp_q);
        mul_b   = cos_q[TW-1] ? 16'(-cos_q) : 16'(cos_q);
        state_d = sh_eval_pkg::ST_E_MI;
      end
      sh_eval_pkg::ST_E_MI: begin
        mul_en  = 1'b1;
        mul_a   = PW'(amp_q);
        mul_b   = sin_q[TW-1] ? 16'(-sin_q) : 16'(sin_q);
        state_d = sh_eval_pkg::ST_E_OUT;
      end
      sh_eval_pkg::ST_E_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = last_w ? sh_eval_pkg::ST_IDLE : sh_eval_pkg::ST_E_RD;
        end
      end
      default: begin
        state_d = sh_eval_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sh_eval_pkg::ST_IDLE;
      orders_used_q <= 4'd8;
      out_valid_q   <= 1'b0;
      div_cnt_q     <= '0;
      l_q           <= '0;
      m_q           <= '0;
      nord_q        <= LW'(1);
      base_q        <= '0;
      phase_q       <= '0;
    end else begin
      state_q <= state_d;
      if (orders_used_we_i) orders_used_q <= orders_used_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_start) begin
        div_cnt_q <= div_cnt_d;
      end else if (div_cnt_q != 6'd0) begin
        div_cnt_q <= div_cnt_q - 6'd1;
      end
      if (in_xfer) begin
        nord_q  <= nord_w;
        l_q     <= '0;
        m_q     <= '0;
        base_q  <= '0;
        phase_q <= '0;
      end
      if (state_q == sh_eval_pkg::ST_INIT) begin
        l_q    <= LW'(1);
        m_q    <= '0;
        base_q <= AW'(1);
        if (nord_q == LW'(1)) begin
          l_q    <= '0;
          base_q <= '0;
        end
      end
      if (state_q == sh_eval_pkg::ST_R_WR) begin
        if (!diag) begin
          m_q <= m_q + 1'b1;
        end else if ((LW + 1)'(l_q) + (LW + 1)'(1) == (LW + 1)'(nord_q)) begin
          // recurrence done, restart counters for the output sweep
          l_q     <= '0;
          m_q     <= '0;
          base_q  <= '0;
          phase_q <= '0;
        end else begin
          l_q    <= l_q + 1'b1;
          m_q    <= '0;
          base_q <= AW'(base_q + AW'(l_q) + AW'(1));
        end
      end
      if (out_load && !last_w) begin
        if (diag) begin
          l_q     <= l_q + 1'b1;
          m_q     <= '0;
          base_q  <= AW'(base_q + AW'(l_q) + AW'(1));
          phase_q <= '0;
        end else begin
          m_q     <= m_q + 1'b1;
          phase_q <= phase_q + phi_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[addr_cur] <= mem_wdata;
    rd_q <= store_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    if (in_xfer) phi_q <= phi_i;
    if (state_q == sh_eval_pkg::ST_TH_WAIT && !cor_busy) begin
      x_q <= cor_cos;
      s_q <= cor_sin[TW-1] ? 16'(-cor_sin) : 16'(cor_sin);
    end
    if (div_start) begin
      div_rem_q <= div_rem_d;
      div_dvd_q <= div_dvd_d;
      div_den_q <= div_den_d;
      div_quo_q <= '0;
    end else if (div_cnt_q != 6'd0) begin
      div_rem_q <= div_ge ? div_sh - {32'h0, div_den_q} : div_sh;
      div_dvd_q <= {div_dvd_q[86:0], 1'b0};
      div_quo_q <= {div_quo_q[62:0], div_ge};
    end
    case (state_q)
      sh_eval_pkg::ST_R_M1: begin
        neg1_q <= rd_q[PW-1] ^ (!diag && x_q[TW-1]);
      end
      sh_eval_pkg::ST_R_M2: begin
        mr_q <= rnd[62:15];
        p2_q <= has_p2 ? rd_q : '0;
      end
      sh_eval_pkg::ST_R_M4: begin
        a_q <= neg1_q ? -$signed(56'(prod_q)) : $signed(56'(prod_q));
      end
      sh_eval_pkg::ST_R_M5: begin
        v_q      <= -64'(a_q);
        numneg_q <= num_w[55];
      end
      sh_eval_pkg::ST_R_DIV: begin
        if (div_cnt_q == 6'd0) v_q <= numneg_q ? -$signed(div_quo_q) : $signed(div_quo_q);
      end
      sh_eval_pkg::ST_E_LD: begin
        p_q   <= rd_q;
        sat_q <= {9'h0, wide_w[87:33]} >= {32'h0, ne_w.s};
      end
      sh_eval_pkg::ST_E_NORM: begin
        if (sat_q || quo33 >= 33'h0_FFFF_FFFF) begin
          amp_q <= 31'h7FFF_FFFF;
        end else begin
          amp_q <= 31'((quo33 + 33'd1) >> 1);
        end
        neg_q <= p_q[PW-1] ^ m_q[0];
        cos_q <= cor_cos;
        sin_q <= cor_sin;
      end
      sh_eval_pkg::ST_E_MI: begin
        yr_q <= y_sat;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      deg_q  <= 3'(l_q);
      ord_q  <= 3'(m_q);
      yre_q  <= yr_q;
      yim_q  <= y_sat;
      last_q <= last_w;
    end
  end

  assign in_ready_o  = (state_q == sh_eval_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign degree_o    = deg_q;
  assign order_o     = ord_q;
  assign y_real_o    = yre_q;
  assign y_imag_o    = yim_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/core/sh_eval_checker.sv =====
// Port-level checks for spherical_harmonics_eval, attached with a bind.
// Depends only on the top level's ports.
module sh_eval_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         degree_o,
  input logic [2:0]         order_o,
  input logic signed [31:0] y_real_o,
  input logic signed [31:0] y_imag_o,
  input logic               last_o
);

  // a direction transfer starts a long evaluation
  a_busy_after_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // the final harmonic is always a diagonal term
  a_last_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> order_o == degree_o)
    else $error("last result is not m equal to n");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped without transfer");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(y_real_o) && $stable(y_imag_o) && $stable(last_o))
    else $error("output payload changed while stalled");

endmodule

bind spherical_harmonics_eval sh_eval_checker u_sh_eval_checker (.*);
